// File: sv/mbl_pkg.sv
`timescale 1ns / 1ps
// Shared types, register codes and helpers for the multi-box line convolution.
// No dependencies; every other file imports this package.
package mbl_pkg;

  localparam int SAMPLE_W = 17;

  typedef enum logic [1:0] {
    FMT_U8  = 2'd0,
    FMT_S8  = 2'd1,
    FMT_U16 = 2'd2,
    FMT_S16 = 2'd3
  } fmt_t;

  typedef enum logic [2:0] {
    REG_LINE_COUNT    = 3'd0,
    REG_MASK_WIDTH    = 3'd1,
    REG_LINE_STARTS   = 3'd2,
    REG_LINE_ENDS     = 3'd3,
    REG_LINE_FACTORS  = 3'd4,
    REG_DIVISOR       = 3'd5,
    REG_OFFSET        = 3'd6,
    REG_SAMPLE_FORMAT = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [2:0]         line_count;
    logic [6:0]         mask_width;
    logic [31:0]        line_starts;
    logic [31:0]        line_ends;
    logic [63:0]        line_factors;
    logic signed [20:0] divisor;
    logic signed [16:0] offset;
    fmt_t               sample_format;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       line_begin;
  } item_t;

  typedef enum logic [1:0] {
    A_IDLE,
    A_SWEEP,
    A_MAC,
    A_HAND
  } acc_state_t;

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_FIN,
    D_OUT
  } div_state_t;

  // Width of one segment sum for a window of mw samples.
  function automatic int sum_width(int mw);
    return 18 + $clog2(mw);
  endfunction

  // Width of the weighted total of up to four segment sums.
  function automatic int acc_width(int mw);
    return sum_width(mw) + 19;
  endfunction

  // Keeps only the bits that the format defines, sign extended where signed.
  function automatic logic signed [SAMPLE_W-1:0] take_sample(logic [SAMPLE_W-1:0] raw,
                                                              fmt_t fmt);
    logic signed [SAMPLE_W-1:0] v;
    case (fmt)
      FMT_U8:  v = {9'b0, raw[7:0]};
      FMT_S8:  v = {{9{raw[7]}}, raw[7:0]};
      FMT_U16: v = {1'b0, raw[15:0]};
      default: v = {raw[15], raw[15:0]};
    endcase
    return v;
  endfunction

endpackage

// File: sv/multi_box_line_convolution.sv
`timescale 1ns / 1ps
// Top level: configuration registers, input queue, window/sum unit and divider.
// Depends on mbl_pkg, mbl_queue, mbl_accum and mbl_div.
//
//   Channel  Handshake              Payload
//   input    in_valid / in_ready    sample, line_begin
//   output   out_valid / out_ready  filtered_sample
//   config   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each item passes through the window sweep, then through the weighted total when a
// result follows; the sweep sets the rate.
// The divider then runs the division and overlaps the next sweep.
// Reset clears the state machines, queue pointers, window fill and window, and sets the registers to their defaults.
// A two-entry input queue and the result register let either side stall on its own.
module multi_box_line_convolution import mbl_pkg::*; #(
  parameter int MAX_WINDOW   = 64,
  parameter int MAX_SEGMENTS = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       line_begin,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] filtered_sample,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [2:0]                 cfg_index,
  input  logic [63:0]                cfg_data
);

  localparam int AW = acc_width(MAX_WINDOW);

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  item_ready;
  logic  acc_valid;
  logic  acc_ready;
  logic signed [AW-1:0] acc;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_count    <= '0;
      cfg.mask_width    <= 7'd1;
      cfg.line_starts   <= '0;
      cfg.line_ends     <= '0;
      cfg.line_factors  <= '0;
      cfg.divisor       <= 21'sd1;
      cfg.offset        <= '0;
      cfg.sample_format <= FMT_U8;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LINE_COUNT:    cfg.line_count    <= cfg_data[2:0];
        REG_MASK_WIDTH:    cfg.mask_width    <= cfg_data[6:0];
        REG_LINE_STARTS:   cfg.line_starts   <= cfg_data[31:0];
        REG_LINE_ENDS:     cfg.line_ends     <= cfg_data[31:0];
        REG_LINE_FACTORS:  cfg.line_factors  <= cfg_data;
        REG_DIVISOR:       cfg.divisor       <= cfg_data[20:0];
        REG_OFFSET:        cfg.offset        <= cfg_data[16:0];
        REG_SAMPLE_FORMAT: cfg.sample_format <= fmt_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  mbl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (sample),
    .line_begin (line_begin),
    .fmt        (cfg.sample_format),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  mbl_accum #(
    .MAX_WINDOW   (MAX_WINDOW),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_accum (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .acc_valid  (acc_valid),
    .acc_ready  (acc_ready),
    .acc        (acc)
  );

  mbl_div #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_div (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .acc_valid       (acc_valid),
    .acc_ready       (acc_ready),
    .acc             (acc),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .filtered_sample (filtered_sample)
  );

endmodule

// File: sv/mbl_queue.sv
`timescale 1ns / 1ps
// Front end: takes input transfers, applies the sample format and queues them.
// Depends on mbl_pkg.
module mbl_queue import mbl_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       line_begin,
  input  fmt_t                       fmt,
  output logic                       item_valid,
  input  logic                       item_ready,
  output item_t                      item
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready   = (count != 2'd2);
  assign item_valid = (count != 2'd0);
  assign item       = slots[rd_ptr];
  assign push       = in_valid && in_ready;
  assign pop        = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr].sample     <= take_sample(sample, fmt);
      slots[wr_ptr].line_begin <= line_begin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/mbl_accum.sv
`timescale 1ns / 1ps
// Back end, first half: sample window, segment sums and the weighted total.
// Depends on mbl_pkg.
module mbl_accum import mbl_pkg::*; #(
  parameter int MAX_WINDOW   = 64,
  parameter int MAX_SEGMENTS = 4
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  cfg_t                                   cfg,
  input  logic                                   item_valid,
  output logic                                   item_ready,
  input  item_t                                  item,
  output logic                                   acc_valid,
  input  logic                                   acc_ready,
  output logic signed [acc_width(MAX_WINDOW)-1:0] acc
);

  localparam int IW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int FW   = $clog2(MAX_WINDOW + 1);
  localparam int NSEG = (MAX_SEGMENTS < 4) ? MAX_SEGMENTS : 4;
  localparam int KW   = (NSEG > 1) ? $clog2(NSEG) : 1;
  localparam int SW   = sum_width(MAX_WINDOW);
  localparam int AW   = acc_width(MAX_WINDOW);
  localparam int PW   = 10;

  acc_state_t state, state_next;

  logic signed [SAMPLE_W-1:0] win [MAX_WINDOW];
  logic signed [SW-1:0]       sums [NSEG];
  logic [IW-1:0]              cnt;
  logic [FW-1:0]              fill;
  logic [FW-1:0]              fill_base;
  logic [KW-1:0]              kidx;

  logic [PW-1:0] mw;
  logic [PW-1:0] w_eff;
  logic [PW-1:0] base;
  logic [PW-1:0] pos;
  logic [PW-1:0] rel;
  logic [2:0]    nseg;
  logic [NSEG-1:0] hit;
  logic          sweep_last;
  logic          mac_last;
  logic          window_full;
  logic signed [15:0]    factor;
  logic signed [SW+15:0] product;

  assign mw    = PW'(cfg.mask_width);
  assign w_eff = (mw == '0) ? PW'(1) : ((mw > PW'(MAX_WINDOW)) ? PW'(MAX_WINDOW) : mw);
  assign base  = PW'(MAX_WINDOW) - w_eff;
  assign nseg  = (cfg.line_count > 3'(NSEG)) ? 3'(NSEG) : cfg.line_count;
  // The window rotates once per sweep cycle, so win[0] holds original slot cnt.
  assign pos   = PW'(cnt);
  assign rel   = pos - base;

  for (genvar k = 0; k < NSEG; k++) begin : g_seg
    logic [PW-1:0] st;
    logic [PW-1:0] en;
    logic [PW-1:0] en_c;
    assign st     = PW'(cfg.line_starts[8*k +: 8]);
    assign en     = PW'(cfg.line_ends[8*k +: 8]);
    assign en_c   = (en > w_eff) ? w_eff : en;
    assign hit[k] = (3'(k) < nseg) && (pos >= base) && (rel >= st) && (rel < en_c);
  end

  assign sweep_last  = (cnt == IW'(MAX_WINDOW - 1));
  assign mac_last    = (kidx == KW'(NSEG - 1));
  assign window_full = !(PW'(fill) < w_eff);
  assign factor      = $signed(cfg.line_factors[16*kidx +: 16]);
  assign product     = factor * sums[kidx];
  assign fill_base   = item.line_begin ? '0 : fill;

  always_comb begin
    state_next = state;
    unique case (state)
      A_IDLE:  if (item_valid) state_next = A_SWEEP;
      A_SWEEP: if (sweep_last) state_next = window_full ? A_MAC : A_IDLE;
      A_MAC:   if (mac_last) state_next = A_HAND;
      A_HAND:  if (acc_ready) state_next = A_IDLE;
      default: state_next = A_IDLE;
    endcase
  end

  always_comb begin
    item_ready = 1'b0;
    acc_valid  = 1'b0;
    unique case (state)
      A_IDLE:  item_ready = 1'b1;
      A_HAND:  acc_valid  = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      fill  <= '0;
      for (int i = 0; i < MAX_WINDOW; i++) win[i] <= '0;
    end else begin
      state <= state_next;
      if (state == A_IDLE && item_valid) begin
        for (int i = 0; i < MAX_WINDOW - 1; i++) begin
          win[i] <= item.line_begin ? '0 : win[i+1];
        end
        win[MAX_WINDOW-1] <= item.sample;
        fill <= (fill_base < FW'(MAX_WINDOW)) ? fill_base + FW'(1) : fill_base;
      end else if (state == A_SWEEP) begin
        for (int i = 0; i < MAX_WINDOW - 1; i++) win[i] <= win[i+1];
        win[MAX_WINDOW-1] <= win[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      A_IDLE: begin
        cnt <= '0;
        for (int k = 0; k < NSEG; k++) sums[k] <= '0;
      end
      A_SWEEP: begin
        cnt  <= cnt + IW'(1);
        kidx <= '0;
        acc  <= '0;
        for (int k = 0; k < NSEG; k++) begin
          if (hit[k]) sums[k] <= sums[k] + SW'(win[0]);
        end
      end
      A_MAC: begin
        kidx <= kidx + KW'(1);
        acc  <= acc + AW'(product);
      end
      default: ;
    endcase
  end

endmodule

// File: sv/mbl_div.sv
`timescale 1ns / 1ps
// Back end, second half: rounding, restoring divide, offset, clip and result register.
// Depends on mbl_pkg.
module mbl_div import mbl_pkg::*; #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  cfg_t                                    cfg,
  input  logic                                    acc_valid,
  output logic                                    acc_ready,
  input  logic signed [acc_width(MAX_WINDOW)-1:0] acc,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [SAMPLE_W-1:0]              filtered_sample
);

  localparam int AW = acc_width(MAX_WINDOW);
  localparam int NW = AW + 1;
  localparam int CW = $clog2(NW + 1);

  div_state_t state, state_next;

  logic signed [20:0] d_eff;
  logic signed [21:0] dp1;
  logic signed [21:0] rnd;
  logic signed [NW-1:0] num;
  logic [21:0]   d_abs;
  logic [NW-1:0] quo;
  logic [20:0]   dmag;
  logic [21:0]   rem;
  logic [21:0]   trial;
  logic          neg;
  logic [CW-1:0] iter;
  logic signed [NW+1:0] qs;
  logic signed [NW+1:0] lo;
  logic signed [NW+1:0] hi;
  logic signed [NW+1:0] clipped;

  assign d_eff = (cfg.divisor == '0) ? 21'sd1 : cfg.divisor;
  assign dp1   = 22'(d_eff) + 22'sd1;
  // Halving toward zero: negative values get one added before the shift.
  assign rnd   = (dp1 < 0) ? ((dp1 + 22'sd1) >>> 1) : (dp1 >>> 1);
  assign num   = NW'(acc) + NW'(rnd);
  assign d_abs = (d_eff < 0) ? 22'(-22'(d_eff)) : 22'(d_eff);
  assign trial = {rem[20:0], quo[NW-1]};

  always_comb begin
    case (cfg.sample_format)
      FMT_U8:  begin lo = '0;            hi = (NW+2)'(255);   end
      FMT_S8:  begin lo = -(NW+2)'(128);  hi = (NW+2)'(127);   end
      FMT_U16: begin lo = '0;            hi = (NW+2)'(65535); end
      default: begin lo = -(NW+2)'(32768); hi = (NW+2)'(32767); end
    endcase
    qs = neg ? -(NW+2)'(quo) : (NW+2)'(quo);
    qs = qs + (NW+2)'(cfg.offset);
    clipped = (qs < lo) ? lo : ((qs > hi) ? hi : qs);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      D_IDLE:  if (acc_valid) state_next = D_RUN;
      D_RUN:   if (iter == CW'(NW - 1)) state_next = D_FIN;
      D_FIN:   state_next = D_OUT;
      D_OUT:   if (out_ready) state_next = D_IDLE;
      default: state_next = D_IDLE;
    endcase
  end

  always_comb begin
    acc_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      D_IDLE:  acc_ready = 1'b1;
      D_OUT:   out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= D_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      D_IDLE: begin
        quo  <= (num < 0) ? NW'(-num) : NW'(num);
        neg  <= (num < 0) != (d_eff < 0);
        dmag <= d_abs[20:0];
        rem  <= '0;
        iter <= '0;
      end
      D_RUN: begin
        iter <= iter + CW'(1);
        if (trial >= {1'b0, dmag}) begin
          rem <= trial - {1'b0, dmag};
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[NW-2:0], 1'b0};
        end
      end
      D_FIN: filtered_sample <= clipped[SAMPLE_W-1:0];
      default: ;
    endcase
  end

endmodule
